// ----- rtl/signed_int_to_decimal_ascii_top_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for signed_int_to_decimal_ascii_top
// Shared property templates used by the conversion logic.
// ----------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define ITOA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define ITOA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/itoa_pkg.sv -----
// ----------------------------------------------------------------------------
// itoa_pkg
// Types, character codes and decimal weight helpers for the converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam logic [6:0] ASCII_ZERO  = 7'd48;
   localparam logic [6:0] ASCII_MINUS = 7'd45;
   localparam int         MAX_POW     = 19;

   // Back end sequencer states
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SIGN,
      BK_DIGIT
   } back_state_type;

   // Queue occupancy flags
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // Ten to the power p, 64 bits (p up to 19)
   function automatic logic [63:0] pow10(input int p);
      logic [63:0] acc;
      acc = 64'd1;
      for (int i = 0; i < p; i++) begin
         acc = acc * 64'd10;
      end
      return acc;
   endfunction

   // Weight of digit k at decimal place p
   function automatic logic [63:0] dec_weight(input int k, input int p);
      logic [63:0] res;
      res = 64'(k) * pow10(p);
      return res;
   endfunction

   // Decimal places needed for the largest magnitude, 2**(bits-1)
   function automatic int digit_count(input int bits);
      logic [63:0] top;
      int          n;
      top = 64'd1 << (bits - 1);
      n   = 0;
      for (int p = 0; p <= MAX_POW; p++) begin
         if (pow10(p) <= top) begin
            n = p + 1;
         end
      end
      return n;
   endfunction

endpackage

// ----- rtl/itoa_if.sv -----
// ----------------------------------------------------------------------------
// itoa channel interfaces
// Valid/ready channels for the integer input and the character output.
// ----------------------------------------------------------------------------
interface itoa_req_if #(
   parameter int VALUE_BITS = 32
);
   logic                         valid;
   logic                         ready;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface itoa_rsp_if;
   logic       valid;
   logic       ready;
   logic [6:0] character;
   logic       last;

   modport source (output valid, output character, output last, input ready);
   modport sink   (input valid, input character, input last, output ready);
endinterface

// ----- rtl/itoa_front.sv -----
// ----------------------------------------------------------------------------
// itoa_front
// Accepts input words, splits them into sign and unsigned magnitude.
// ----------------------------------------------------------------------------
module itoa_front #(
   parameter int VALUE_BITS = 32
) (
   itoa_req_if.sink               req_ch,
   input  itoa_pkg::qstat_type    qstat,
   output logic                   push,
   output logic                   push_neg,
   output logic [VALUE_BITS-1:0]  push_mag
);

   // Take a word whenever the queue has room
   assign req_ch.ready = !qstat.full;
   assign push         = req_ch.valid && !qstat.full;

   // Classify: sign bit and magnitude (most negative value wraps to 2**(n-1))
   always_comb begin
      push_neg = req_ch.value[VALUE_BITS-1];
      push_mag = push_neg ? (~req_ch.value + 1'b1) : req_ch.value;
   end

endmodule

// ----- rtl/itoa_queue.sv -----
// ----------------------------------------------------------------------------
// itoa_queue
// Two-entry queue of classified words between front and back end.
// ----------------------------------------------------------------------------
module itoa_queue #(
   parameter int VALUE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic                   push_neg,
   input  logic [VALUE_BITS-1:0]  push_mag,
   input  logic                   pop,
   output logic                   pop_neg,
   output logic [VALUE_BITS-1:0]  pop_mag,
   output itoa_pkg::qstat_type    qstat
);

   logic                  neg_ff [2];
   logic [VALUE_BITS-1:0] mag_ff [2];
   logic                  wr_ptr_ff, wr_ptr_in;
   logic                  rd_ptr_ff, rd_ptr_in;
   logic [1:0]            count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         neg_ff[wr_ptr_ff] <= push_neg;
         mag_ff[wr_ptr_ff] <= push_mag;
      end
   end

   assign pop_neg     = neg_ff[rd_ptr_ff];
   assign pop_mag     = mag_ff[rd_ptr_ff];
   assign qstat.full  = count_ff == 2'd2;
   assign qstat.empty = count_ff == 2'd0;

endmodule

// ----- rtl/itoa_back.sv -----
// ----------------------------------------------------------------------------
// itoa_back
// Digit sequencer: one decimal place per cycle while the output register is free,
// most significant first, with the character output register.
// ----------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_top_defines.svh"

module itoa_back #(
   parameter int VALUE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  itoa_pkg::qstat_type    qstat,
   input  logic                   pop_neg,
   input  logic [VALUE_BITS-1:0]  pop_mag,
   output logic                   pop,
   itoa_rsp_if.source             rsp_ch
);

   localparam int NDIG  = itoa_pkg::digit_count(VALUE_BITS);
   localparam int POS_W = $clog2(NDIG);
   localparam logic [POS_W-1:0] TOP_POS = POS_W'(NDIG - 1);

   itoa_pkg::back_state_type state_ff, state_in;
   logic [VALUE_BITS-1:0]    mag_ff, mag_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic                     started_ff, started_in;
   logic                     out_valid_ff, out_valid_in;
   logic [6:0]               out_char_ff, out_char_in;
   logic                     out_last_ff, out_last_in;

   logic                     adv;
   logic                     emit;
   logic                     load;
   logic [3:0]               digit;
   logic [63:0]              mag_ext;
   logic [63:0]              sel_weight;
   logic [VALUE_BITS-1:0]    mag_rem;
   logic [63:0]              weight [NDIG][10];

   // Constant table of digit weights
   for (genvar p = 0; p < NDIG; p++) begin : g_place
      for (genvar k = 0; k < 10; k++) begin : g_digit
         localparam logic [63:0] WK = itoa_pkg::dec_weight(k, p);
         assign weight[p][k] = WK;
      end
   end

   // Pick the digit at the current place and the remainder below it
   always_comb begin
      mag_ext = 64'(mag_ff);
      digit   = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (mag_ext >= weight[pos_ff][k]) begin
            digit = 4'(k);
         end
      end
      sel_weight = weight[pos_ff][digit];
      mag_rem    = VALUE_BITS'(mag_ext - sel_weight);
   end

   // Output register frees up when empty or being taken
   assign adv = !out_valid_ff || rsp_ch.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         itoa_pkg::BK_IDLE: begin
            if (!qstat.empty) begin
               state_in = pop_neg ? itoa_pkg::BK_SIGN : itoa_pkg::BK_DIGIT;
            end
         end
         itoa_pkg::BK_SIGN: begin
            if (adv) begin
               state_in = itoa_pkg::BK_DIGIT;
            end
         end
         itoa_pkg::BK_DIGIT: begin
            if (adv && pos_ff == '0) begin
               if (qstat.empty) begin
                  state_in = itoa_pkg::BK_IDLE;
               end else begin
                  state_in = pop_neg ? itoa_pkg::BK_SIGN : itoa_pkg::BK_DIGIT;
               end
            end
         end
         default: begin
            state_in = itoa_pkg::BK_IDLE;
         end
      endcase
   end

   // Datapath controls and outputs
   always_comb begin
      load        = 1'b0;
      emit        = 1'b0;
      out_char_in = out_char_ff;
      out_last_in = out_last_ff;
      mag_in      = mag_ff;
      pos_in      = pos_ff;
      started_in  = started_ff;
      case (state_ff)
         itoa_pkg::BK_IDLE: begin
            load = !qstat.empty;
         end
         itoa_pkg::BK_SIGN: begin
            if (adv) begin
               emit        = 1'b1;
               out_char_in = itoa_pkg::ASCII_MINUS;
               out_last_in = 1'b0;
            end
         end
         itoa_pkg::BK_DIGIT: begin
            if (adv) begin
               emit        = (digit != 4'd0) || started_ff || (pos_ff == '0);
               out_char_in = itoa_pkg::ASCII_ZERO + 7'(digit);
               out_last_in = pos_ff == '0;
               mag_in      = mag_rem;
               started_in  = started_ff || (digit != 4'd0);
               pos_in      = pos_ff - 1'b1;
               load        = (pos_ff == '0) && !qstat.empty;
            end
         end
         default: begin
            load = 1'b0;
         end
      endcase
      // Start a fresh word at the top place
      if (load) begin
         mag_in     = pop_mag;
         pos_in     = TOP_POS;
         started_in = 1'b0;
      end
   end

   assign pop          = load;
   assign out_valid_in = emit || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itoa_pkg::BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Hold payload unless a new character is emitted
   always_ff @(posedge clock) begin
      mag_ff     <= mag_in;
      pos_ff     <= pos_in;
      started_ff <= started_in;
      if (emit) begin
         out_char_ff <= out_char_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.character = out_char_ff;
   assign rsp_ch.last      = out_last_ff;

   `ITOA_ASSERT_IMP(a_pop_at_boundary, clock, reset, pop,
      (state_ff == itoa_pkg::BK_IDLE) || (state_ff == itoa_pkg::BK_DIGIT && pos_ff == '0),
      "queue popped in the middle of a word")
   `ITOA_ASSERT_IMP(a_units_always_emitted, clock, reset,
      state_ff == itoa_pkg::BK_DIGIT && adv && pos_ff == '0, emit && out_last_in,
      "units digit not emitted as last character")
   `ITOA_ASSERT_NXT(a_sign_then_digits, clock, reset,
      state_ff == itoa_pkg::BK_SIGN && adv,
      state_ff == itoa_pkg::BK_DIGIT && pos_ff == TOP_POS && !out_last_ff,
      "minus sign not followed by the digit run")
   `ITOA_ASSERT_IMP(a_no_emit_stalled, clock, reset, out_valid_ff && !rsp_ch.ready, !emit,
      "character overwritten while stalled")

endmodule

// ----- rtl/signed_int_to_decimal_ascii_top.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Signed integer to decimal ASCII text, one character per output word.
//
//   Channel  Dir  Payload                    Notes
//   req_ch   in   value[VALUE_BITS-1:0] s    one integer per word
//   rsp_ch   out  character[6:0], last       '-' then digits, last on units
//
// The digit sequencer in the back end steps through every decimal place of an
// integer, most significant first, after a minus sign for a negative integer.
// A word that finds the back end idle is loaded in the idle state first.
// Leading zero places are stepped through but not emitted.
// A two-entry queue lets the input side keep taking words while output stalls, until it fills.
// Synchronous active-high reset empties the queue and the output register.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top #(
   parameter int VALUE_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   itoa_req_if.sink    req_ch,
   itoa_rsp_if.source  rsp_ch
);

   itoa_pkg::qstat_type   qstat;
   logic                  push;
   logic                  push_neg;
   logic [VALUE_BITS-1:0] push_mag;
   logic                  pop;
   logic                  pop_neg;
   logic [VALUE_BITS-1:0] pop_mag;

   // Classify incoming words
   itoa_front #(.VALUE_BITS(VALUE_BITS)) u_front (
      .req_ch   (req_ch),
      .qstat    (qstat),
      .push     (push),
      .push_neg (push_neg),
      .push_mag (push_mag)
   );

   // Decouple front and back
   itoa_queue #(.VALUE_BITS(VALUE_BITS)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_neg (push_neg),
      .push_mag (push_mag),
      .pop      (pop),
      .pop_neg  (pop_neg),
      .pop_mag  (pop_mag),
      .qstat    (qstat)
   );

   // Emit characters
   itoa_back #(.VALUE_BITS(VALUE_BITS)) u_back (
      .clock    (clock),
      .reset    (reset),
      .qstat    (qstat),
      .pop_neg  (pop_neg),
      .pop_mag  (pop_mag),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ----- tb/signed_int_to_decimal_ascii_top_tb.sv -----
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top_tb
// Self-checking bench for the signed integer to decimal text converter.
// A short table of integers (zero, one digit, powers of ten, both 32-bit
// extremes) is sent first, then about 340 random integers spread over full
// range, every digit count and the corners. Each integer taken is turned
// into its expected run of characters, and every character word leaving the
// block is checked in order against that run. Both channels stall in random
// bursts, and the final stretch runs with no stalls.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_BITS    = 32;
   localparam int DECIMAL_RADIX = 10;
   localparam int MAX_DIGITS    = 10;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES  = 40;
   localparam int RANDOM_BLOCKS = 8;
   localparam int BLOCK_ITEMS   = 42;
   localparam int TABLE_ROWS    = 20;

   // One character word as it leaves the block
   typedef struct packed {
      logic [6:0] character;
      logic       last;
   } char_word_type;

   // Table row: an empty text means the predictor supplies the characters
   typedef struct {
      logic [VALUE_BITS-1:0] value;
      string                 text;
   } text_case_type;

   logic clock = 1'b0;
   logic reset;

   itoa_req_if #(.VALUE_BITS(VALUE_BITS)) req_ch ();
   itoa_rsp_if                            rsp_ch ();

   signed_int_to_decimal_ascii_top #(
      .VALUE_BITS(VALUE_BITS)
   ) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   char_word_type expected_chars [$];
   string         pending_texts [$];
   int            fail_count   = 0;
   int            cycle_count  = 0;
   int            sink_hold    = 0;
   bit            source_idling = 1'b0;
   bit            sink_idling   = 1'b0;

   text_case_type text_cases [TABLE_ROWS] = '{
      '{32'd0,          "0"},
      '{32'd1,          "1"},
      '{32'hFFFF_FFFF,  "-1"},
      '{32'd9,          "9"},
      '{32'd10,         "10"},
      '{-32'sd10,       "-10"},
      '{32'd99,         ""},
      '{32'd100,        "100"},
      '{32'h7FFF_FFFF,  "2147483647"},
      '{32'h8000_0000,  "-2147483648"},
      '{32'h8000_0001,  "-2147483647"},
      '{32'd1000000000, "1000000000"},
      '{32'd999999999,  "999999999"},
      '{-32'sd999999999, "-999999999"},
      '{32'h5555_5555,  ""},
      '{32'hAAAA_AAAA,  ""},
      '{32'd123456789,  ""},
      '{-32'sd100000,   ""},
      '{32'h7FFF_0000,  ""},
      '{32'd2147483640, ""}
   };

   // Free-running clock, 10 ns period
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expand one integer into its decimal characters, sign first
   function automatic void predict_text(input logic [VALUE_BITS-1:0] v);
      logic [VALUE_BITS-1:0] magnitude;
      logic [3:0]            digits [MAX_DIGITS];
      int                    n;
      magnitude = v[VALUE_BITS-1] ? (~v + 1'b1) : v;
      n = 0;
      do begin
         digits[n] = 4'(magnitude % DECIMAL_RADIX);
         magnitude = magnitude / DECIMAL_RADIX;
         n++;
      end while (magnitude != 0);
      if (v[VALUE_BITS-1]) begin
         expected_chars.push_back('{itoa_pkg::ASCII_MINUS, 1'b0});
      end
      for (int k = n - 1; k >= 0; k--) begin
         expected_chars.push_back('{itoa_pkg::ASCII_ZERO + 7'(digits[k]), k == 0});
      end
   endfunction

   // Present one integer and hold it until the block takes it
   task automatic send_value(input logic [VALUE_BITS-1:0] v, input string text);
      pending_texts.push_back(text);
      req_ch.valid <= 1'b1;
      req_ch.value <= v;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Drop valid for a random burst when the sender is idling
   task automatic source_gap();
      if (source_idling && $urandom_range(0, 3) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(negedge clock);
      end
   endtask

   // Hold the sender until every expected character has left
   task automatic drain_text();
      req_ch.valid <= 1'b0;
      while (expected_chars.size() != 0 || pending_texts.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Stall the character channel in random bursts
   always @(negedge clock) begin
      if (sink_hold > 0) begin
         sink_hold = sink_hold - 1;
         rsp_ch.ready <= 1'b0;
      end else if (sink_idling && $urandom_range(0, 5) == 0) begin
         sink_hold = $urandom_range(1, 14) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Abort a run that hangs
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Queue the text of each integer taken, then check each character word
   always @(posedge clock) begin : scoreboard
      string         row_text;
      byte           text_char;
      char_word_type want;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            row_text = (pending_texts.size() != 0) ? pending_texts.pop_front() : "";
            if (row_text.len() == 0) begin
               predict_text(req_ch.value);
            end else begin
               for (int i = 0; i < row_text.len(); i++) begin
                  text_char = row_text[i];
                  expected_chars.push_back('{text_char[6:0], i == row_text.len() - 1});
               end
            end
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_chars.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word, expected none, got char %0d last %0b",
                        $realtime, rsp_ch.character, rsp_ch.last);
            end else begin
               want = expected_chars.pop_front();
               if (rsp_ch.character !== want.character || rsp_ch.last !== want.last) begin
                  fail_count++;
                  $display("%0t: mismatch, expected char %0d last %0b, got char %0d last %0b",
                           $realtime, want.character, want.last,
                           rsp_ch.character, rsp_ch.last);
               end
            end
         end
      end
   end

   // Reset, table, random blocks, drain
   initial begin : stimulus
      logic [VALUE_BITS-1:0] value;
      logic [VALUE_BITS-1:0] span_lo;
      logic [VALUE_BITS-1:0] span_hi;
      int                    places;
      int                    pick;

      reset        = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.value = '0;
      rsp_ch.ready = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the table with the output side stalling
      sink_idling   = 1'b1;
      source_idling = 1'b1;
      foreach (text_cases[i]) begin
         send_value(text_cases[i].value, text_cases[i].text);
         source_gap();
      end
      drain_text();

      for (int b = 0; b < RANDOM_BLOCKS; b++) begin
         // First block stalls both sides, second none, last none, others at random
         if (b == 0) begin
            source_idling = 1'b1;
            sink_idling   = 1'b1;
         end else if (b == 1 || b == RANDOM_BLOCKS - 1) begin
            source_idling = 1'b0;
            sink_idling   = 1'b0;
         end else begin
            source_idling = $urandom_range(0, 1);
            sink_idling   = $urandom_range(0, 1);
         end
         for (int n = 0; n < BLOCK_ITEMS; n++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               value = $urandom;
            end else if (pick < 8) begin
               // Random digit count, random sign
               places = $urandom_range(1, MAX_DIGITS);
               span_lo = 1;
               repeat (places - 1) span_lo = span_lo * DECIMAL_RADIX;
               if (places == MAX_DIGITS) begin
                  span_hi = 32'h7FFF_FFFF;
               end else begin
                  span_hi = span_lo * DECIMAL_RADIX - 1;
               end
               if (places == 1) begin
                  span_lo = 0;
               end
               value = $urandom_range(span_hi, span_lo);
               if ($urandom_range(0, 1) == 1) begin
                  value = -value;
               end
            end else begin
               // Corners: near either extreme, near zero, next to a power of ten
               case ($urandom_range(0, 3))
                  0: value = 32'h7FFF_FFFF - $urandom_range(0, 20);
                  1: value = 32'h8000_0000 + $urandom_range(0, 20);
                  2: value = $urandom_range(0, 20) - 10;
                  default: begin
                     span_lo = 1;
                     repeat ($urandom_range(1, MAX_DIGITS - 1))
                        span_lo = span_lo * DECIMAL_RADIX;
                     value = span_lo + $urandom_range(0, 2) - 1;
                     if ($urandom_range(0, 1) == 1) begin
                        value = -value;
                     end
                  end
               endcase
            end
            send_value(value, "");
            source_gap();
         end
         if (b == RANDOM_BLOCKS / 2) begin
            drain_text();
         end
      end

      req_ch.valid <= 1'b0;
      while (expected_chars.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/itoa_pkg.sv
rtl/itoa_if.sv
rtl/itoa_front.sv
rtl/itoa_queue.sv
rtl/itoa_back.sv
rtl/signed_int_to_decimal_ascii_top.sv
tb/signed_int_to_decimal_ascii_top_tb.sv
